[sv/mfar_pkg.sv]
// ----------------------------------------------------------------------------
// Mixed fraction add/reduce package
// Shared constants, operation codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package mfar_pkg;

	localparam int OPERAND_WIDTH_DEF = 16;
	localparam int RES_WHOLE_W       = 48;
	localparam int RES_NUM_W         = 31;
	localparam int RES_DEN_W         = 31;
	localparam int REQ_TYPE_W        = 2;

	localparam logic [REQ_TYPE_W-1:0] OP_ADD = 2'd0;
	localparam logic [REQ_TYPE_W-1:0] OP_SUB = 2'd1;
	localparam logic [REQ_TYPE_W-1:0] OP_NEG = 2'd2;
	localparam logic [REQ_TYPE_W-1:0] OP_NOP = 2'd3;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_MUL_START,
		CMD_MUL_STEP,
		CMD_COMBINE,
		CMD_GCD_START,
		CMD_GCD_STEP,
		CMD_DIV_START,
		CMD_DIV_STEP,
		CMD_WRITE
	} cmd_kind_t;

	typedef enum logic [2:0] {
		MSEL_MA,
		MSEL_MB,
		MSEL_TA,
		MSEL_TB,
		MSEL_D
	} mul_sel_t;

	typedef enum logic [1:0] {
		DSEL_NM,
		DSEL_D,
		DSEL_QR
	} div_sel_t;

	typedef struct packed {
		cmd_kind_t kind;
		mul_sel_t  msel;
		div_sel_t  dsel;
	} cmd_t;

	typedef struct packed {
		logic short_op;
		logic nm_zero;
		logic mul_last;
		logic div_last;
		logic gcd_done;
		logic out_busy;
	} status_t;

endpackage

[sv/mfar_ctrl.sv]
// ----------------------------------------------------------------------------
// Mixed fraction add/reduce controller
// Sequences multiply, combine, GCD and divide steps of the datapath.
// ----------------------------------------------------------------------------
module mfar_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  mfar_pkg::status_t st,
	output mfar_pkg::cmd_t    cmd
);
	import mfar_pkg::*;

	typedef enum logic [8:0] {
		ST_IDLE    = 9'b000000001,
		ST_MUL_GO  = 9'b000000010,
		ST_MUL_RUN = 9'b000000100,
		ST_COMB    = 9'b000001000,
		ST_GCD_GO  = 9'b000010000,
		ST_GCD_RUN = 9'b000100000,
		ST_DIV_GO  = 9'b001000000,
		ST_DIV_RUN = 9'b010000000,
		ST_WRITE   = 9'b100000000
	} state_t;

	state_t   state_q, state_d;
	mul_sel_t msel_q, msel_d;
	div_sel_t dsel_q, dsel_d;

	assign req_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d  = state_q;
		msel_d   = msel_q;
		dsel_d   = dsel_q;
		cmd.kind = CMD_NONE;
		cmd.msel = msel_q;
		cmd.dsel = dsel_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.kind = CMD_LOAD;
					msel_d   = MSEL_MA;
					state_d  = ST_MUL_GO;
				end
			end
			ST_MUL_GO: begin
				if (st.short_op) begin
					state_d = ST_WRITE;
				end else begin
					cmd.kind = CMD_MUL_START;
					state_d  = ST_MUL_RUN;
				end
			end
			ST_MUL_RUN: begin
				cmd.kind = CMD_MUL_STEP;
				if (st.mul_last) begin
					case (msel_q)
						MSEL_MA: begin
							msel_d  = MSEL_MB;
							state_d = ST_MUL_GO;
						end
						MSEL_MB: begin
							msel_d  = MSEL_TA;
							state_d = ST_MUL_GO;
						end
						MSEL_TA: begin
							msel_d  = MSEL_TB;
							state_d = ST_MUL_GO;
						end
						MSEL_TB: begin
							msel_d  = MSEL_D;
							state_d = ST_MUL_GO;
						end
						default: state_d = ST_COMB;
					endcase
				end
			end
			ST_COMB: begin
				cmd.kind = CMD_COMBINE;
				state_d  = ST_GCD_GO;
			end
			ST_GCD_GO: begin
				if (st.nm_zero) begin
					state_d = ST_WRITE;
				end else begin
					cmd.kind = CMD_GCD_START;
					state_d  = ST_GCD_RUN;
				end
			end
			ST_GCD_RUN: begin
				cmd.kind = CMD_GCD_STEP;
				if (st.gcd_done) begin
					dsel_d  = DSEL_NM;
					state_d = ST_DIV_GO;
				end
			end
			ST_DIV_GO: begin
				cmd.kind = CMD_DIV_START;
				state_d  = ST_DIV_RUN;
			end
			ST_DIV_RUN: begin
				cmd.kind = CMD_DIV_STEP;
				if (st.div_last) begin
					case (dsel_q)
						DSEL_NM: begin
							dsel_d  = DSEL_D;
							state_d = ST_DIV_GO;
						end
						DSEL_D: begin
							dsel_d  = DSEL_QR;
							state_d = ST_DIV_GO;
						end
						default: state_d = ST_WRITE;
					endcase
				end
			end
			ST_WRITE: begin
				if (!st.out_busy) begin
					cmd.kind = CMD_WRITE;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			msel_q  <= MSEL_MA;
			dsel_q  <= DSEL_NM;
		end else begin
			state_q <= state_d;
			msel_q  <= msel_d;
			dsel_q  <= dsel_d;
		end
	end

endmodule

[sv/mfar_dp.sv]
// ----------------------------------------------------------------------------
// Mixed fraction add/reduce datapath
// Shift-add multiplier, binary GCD, restoring divider and result register.
// ----------------------------------------------------------------------------
module mfar_dp #(
	parameter int OPERAND_WIDTH = mfar_pkg::OPERAND_WIDTH_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  mfar_pkg::cmd_t                           cmd,
	output mfar_pkg::status_t                        st,
	input  logic [mfar_pkg::REQ_TYPE_W-1:0]          req_type,
	input  logic signed [OPERAND_WIDTH-1:0]          a_whole,
	input  logic signed [OPERAND_WIDTH-1:0]          a_numerator,
	input  logic [OPERAND_WIDTH-2:0]                 a_denominator,
	input  logic signed [OPERAND_WIDTH-1:0]          b_whole,
	input  logic signed [OPERAND_WIDTH-1:0]          b_numerator,
	input  logic [OPERAND_WIDTH-2:0]                 b_denominator,
	output logic                                     res_valid,
	input  logic                                     res_ready,
	output logic signed [mfar_pkg::RES_WHOLE_W-1:0]  res_whole,
	output logic signed [mfar_pkg::RES_NUM_W-1:0]    res_numerator,
	output logic [mfar_pkg::RES_DEN_W-1:0]           res_denominator
);
	import mfar_pkg::*;

	localparam int W  = OPERAND_WIDTH;
	localparam int DW = W - 1;
	localparam int NW = (3 * W > 64) ? 64 : 3 * W;
	localparam int CW = $clog2(NW + 1);

	logic [REQ_TYPE_W-1:0] op_q;
	logic                  sa_q, sb_q, sn_q;
	logic signed [W-1:0]   aw_q, an_q, bw_q, bn_q;
	logic [DW-1:0]         ad_q, bd_q, mplier_q;
	logic [NW-1:0]         ma_q, mb_q, ta_q, tb_q, d_q, nm_q, g_q, q_q, r_q;
	logic [NW-1:0]         acc_q, mcand_q, ga_q, gb_q, dvd_q, rem_q, dsr_q;
	logic [CW-1:0]         cnt_q, k_q;
	logic                  res_valid_q;
	logic [RES_WHOLE_W-1:0] res_whole_q;
	logic [RES_NUM_W-1:0]  res_num_q;
	logic [RES_DEN_W-1:0]  res_den_q;

	logic [W-1:0]  awm, anm, bwm, bnm;
	logic [NW-1:0] acc_nx, quo_nx, rem_nx;
	logic [NW:0]   trial, dsr_x;
	logic          ge;
	logic [RES_WHOLE_W-1:0] wh_n, qx;
	logic [RES_NUM_W-1:0]   nu_n;
	logic [RES_DEN_W-1:0]   de_n;

	assign awm = aw_q[W-1] ? W'('0 - aw_q) : W'(aw_q);
	assign anm = an_q[W-1] ? W'('0 - an_q) : W'(an_q);
	assign bwm = bw_q[W-1] ? W'('0 - bw_q) : W'(bw_q);
	assign bnm = bn_q[W-1] ? W'('0 - bn_q) : W'(bn_q);

	assign acc_nx = acc_q + (mplier_q[0] ? mcand_q : '0);
	assign trial  = {rem_q, dvd_q[NW-1]};
	assign dsr_x  = {1'b0, dsr_q};
	assign ge     = (trial >= dsr_x);
	assign rem_nx = ge ? NW'(trial - dsr_x) : trial[NW-1:0];
	assign quo_nx = {dvd_q[NW-2:0], ge};

	assign st.short_op = (op_q == OP_NEG) || (op_q == OP_NOP);
	assign st.nm_zero  = (nm_q == '0);
	assign st.mul_last = (cnt_q == CW'(DW - 1));
	assign st.div_last = (cnt_q == CW'(NW - 1));
	assign st.gcd_done = (ga_q == '0) || (gb_q == '0);
	assign st.out_busy = res_valid_q && !res_ready;

	// Result formatting.
	always_comb begin
		qx   = RES_WHOLE_W'(q_q);
		wh_n = '0;
		nu_n = '0;
		de_n = RES_DEN_W'(1);
		if (op_q == OP_NEG) begin
			de_n = RES_DEN_W'(ad_q);
			if (aw_q != '0) begin
				wh_n = '0 - RES_WHOLE_W'(aw_q);
				nu_n = RES_NUM_W'(an_q);
			end else begin
				nu_n = '0 - RES_NUM_W'(an_q);
			end
		end else if (op_q != OP_NOP && nm_q != '0) begin
			de_n = RES_DEN_W'(d_q);
			if (q_q != '0) begin
				wh_n = sn_q ? ('0 - qx) : qx;
				nu_n = RES_NUM_W'(r_q);
			end else begin
				nu_n = sn_q ? ('0 - RES_NUM_W'(r_q)) : RES_NUM_W'(r_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.kind)
			CMD_LOAD: begin
				op_q <= req_type;
				aw_q <= a_whole;
				an_q <= a_numerator;
				bw_q <= b_whole;
				bn_q <= b_numerator;
				ad_q <= (a_denominator == '0) ? DW'(1) : a_denominator;
				bd_q <= (b_denominator == '0) ? DW'(1) : b_denominator;
				sa_q <= a_whole[W-1] | a_numerator[W-1];
				sb_q <= (b_whole[W-1] | b_numerator[W-1]) ^ (req_type == OP_SUB);
			end
			CMD_MUL_START: begin
				cnt_q <= '0;
				case (cmd.msel)
					MSEL_MA: begin
						acc_q    <= NW'(anm);
						mcand_q  <= NW'(awm);
						mplier_q <= ad_q;
					end
					MSEL_MB: begin
						acc_q    <= NW'(bnm);
						mcand_q  <= NW'(bwm);
						mplier_q <= bd_q;
					end
					MSEL_TA: begin
						acc_q    <= '0;
						mcand_q  <= ma_q;
						mplier_q <= bd_q;
					end
					MSEL_TB: begin
						acc_q    <= '0;
						mcand_q  <= mb_q;
						mplier_q <= ad_q;
					end
					default: begin
						acc_q    <= '0;
						mcand_q  <= NW'(ad_q);
						mplier_q <= bd_q;
					end
				endcase
			end
			CMD_MUL_STEP: begin
				acc_q    <= acc_nx;
				mcand_q  <= mcand_q << 1;
				mplier_q <= mplier_q >> 1;
				cnt_q    <= cnt_q + CW'(1);
				if (st.mul_last) begin
					case (cmd.msel)
						MSEL_MA: ma_q <= acc_nx;
						MSEL_MB: mb_q <= acc_nx;
						MSEL_TA: ta_q <= acc_nx;
						MSEL_TB: tb_q <= acc_nx;
						default: d_q  <= acc_nx;
					endcase
				end
			end
			CMD_COMBINE: begin
				if (sa_q == sb_q) begin
					nm_q <= ta_q + tb_q;
					sn_q <= sa_q;
				end else if (ta_q >= tb_q) begin
					nm_q <= ta_q - tb_q;
					sn_q <= sa_q;
				end else begin
					nm_q <= tb_q - ta_q;
					sn_q <= sb_q;
				end
			end
			CMD_GCD_START: begin
				ga_q <= nm_q;
				gb_q <= d_q;
				k_q  <= '0;
			end
			CMD_GCD_STEP: begin
				if (st.gcd_done) begin
					g_q <= ((ga_q == '0) ? gb_q : ga_q) << k_q;
				end else if (!ga_q[0] && !gb_q[0]) begin
					ga_q <= ga_q >> 1;
					gb_q <= gb_q >> 1;
					k_q  <= k_q + CW'(1);
				end else if (!ga_q[0]) begin
					ga_q <= ga_q >> 1;
				end else if (!gb_q[0]) begin
					gb_q <= gb_q >> 1;
				end else if (ga_q >= gb_q) begin
					ga_q <= ga_q - gb_q;
				end else begin
					gb_q <= gb_q - ga_q;
				end
			end
			CMD_DIV_START: begin
				cnt_q <= '0;
				rem_q <= '0;
				case (cmd.dsel)
					DSEL_NM: begin
						dvd_q <= nm_q;
						dsr_q <= g_q;
					end
					DSEL_D: begin
						dvd_q <= d_q;
						dsr_q <= g_q;
					end
					default: begin
						dvd_q <= nm_q;
						dsr_q <= d_q;
					end
				endcase
			end
			CMD_DIV_STEP: begin
				rem_q <= rem_nx;
				dvd_q <= quo_nx;
				cnt_q <= cnt_q + CW'(1);
				if (st.div_last) begin
					case (cmd.dsel)
						DSEL_NM: nm_q <= quo_nx;
						DSEL_D:  d_q  <= quo_nx;
						default: begin
							q_q <= quo_nx;
							r_q <= rem_nx;
						end
					endcase
				end
			end
			CMD_WRITE: begin
				res_whole_q <= wh_n;
				res_num_q   <= nu_n;
				res_den_q   <= de_n;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.kind == CMD_WRITE) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign res_valid       = res_valid_q;
	assign res_whole       = res_whole_q;
	assign res_numerator   = res_num_q;
	assign res_denominator = res_den_q;

endmodule

[sv/mixed_fraction_add_reduce_core.sv]
// ----------------------------------------------------------------------------
// Mixed fraction add/reduce core
// Adds or subtracts signed mixed fractions, reduced to lowest terms, or negates operand a.
// ----------------------------------------------------------------------------
// Negate and the unused opcode skip the arithmetic; add and subtract run five shift-add
// multiplies, then the binary GCD loop and three restoring divides unless the sum is zero.
// Throughput: one transaction at a time, set by the shift-add multiplier, GCD loop and
// restoring divider; a new request is taken while a finished result waits for output.
// Reset: arst_n clears the controller and the result valid flag.
module mixed_fraction_add_reduce_core #(
	parameter int OPERAND_WIDTH = mfar_pkg::OPERAND_WIDTH_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     req_valid,
	output logic                                     req_ready,
	input  logic [mfar_pkg::REQ_TYPE_W-1:0]          req_type,
	input  logic signed [OPERAND_WIDTH-1:0]          a_whole,
	input  logic signed [OPERAND_WIDTH-1:0]          a_numerator,
	input  logic [OPERAND_WIDTH-2:0]                 a_denominator,
	input  logic signed [OPERAND_WIDTH-1:0]          b_whole,
	input  logic signed [OPERAND_WIDTH-1:0]          b_numerator,
	input  logic [OPERAND_WIDTH-2:0]                 b_denominator,
	output logic                                     res_valid,
	input  logic                                     res_ready,
	output logic signed [mfar_pkg::RES_WHOLE_W-1:0]  res_whole,
	output logic signed [mfar_pkg::RES_NUM_W-1:0]    res_numerator,
	output logic [mfar_pkg::RES_DEN_W-1:0]           res_denominator
);
	import mfar_pkg::*;

	// The controller issues at most one command per cycle, none while it waits on output
	// back-pressure; the datapath reports counter ends, the GCD finish, a zero sum and back-pressure.
	cmd_t    cmd;
	status_t st;

	mfar_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.st        (st),
		.cmd       (cmd)
	);

	// The datapath latches the request when the controller accepts the
	// transaction, builds the cross-multiplied numerator, reduces it by the
	// GCD and splits it into whole part and remainder.
	mfar_dp #(
		.OPERAND_WIDTH (OPERAND_WIDTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.st              (st),
		.req_type        (req_type),
		.a_whole         (a_whole),
		.a_numerator     (a_numerator),
		.a_denominator   (a_denominator),
		.b_whole         (b_whole),
		.b_numerator     (b_numerator),
		.b_denominator   (b_denominator),
		.res_valid       (res_valid),
		.res_ready       (res_ready),
		.res_whole       (res_whole),
		.res_numerator   (res_numerator),
		.res_denominator (res_denominator)
	);

`ifndef SYNTHESIS
	// Once a request is taken, the core is busy in the cycle after acceptance.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request accepted twice in a row");

	// A delivered denominator is never zero.
	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_denominator != '0))
		else $error("zero result denominator");

	// A new result only appears after the core was busy with a transaction.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(!req_ready))
		else $error("result without a transaction in flight");
`endif

endmodule
